// File: rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// Element geometry, operation and status codes, sequencer states and the
// packed words carried on the input and result channels.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Storage geometry.
  localparam int DEPTH = 1024;
  localparam int WIDTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // Field widths of the channel items.
  localparam int MODE_W = 3;
  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int RDV_W  = 32;
  localparam int CNT_W  = 11;
  localparam int CHG_W  = 64;

  localparam int IN_USED_W    = MODE_W + POS_W + VAL_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W   = 2 + RDV_W + CNT_W + CHG_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // Operation codes; code seven means nothing and fails as out of range.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_GET    = 3'd4,
    MODE_SET    = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LOCKED = 2'd1,
    ST_RANGE  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_REM_HEAD,
    S_REM_SHIFT,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DONE
  } state_t;

  // One write port and one read port of the element memory.
  typedef struct packed {
    logic             we;
    logic [AW-1:0]    waddr;
    logic [WIDTH-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;
  } mem_req_t;

  // Result of one item, handed from the sequencer to the output stage.
  typedef struct packed {
    status_t          status;
    logic [RDV_W-1:0] read_value;
    logic [CNT_W-1:0] entry_count;
    logic [CHG_W-1:0] change_number;
  } result_t;

  // Input item as packed on in_tdata, lowest field last.
  typedef struct packed {
    logic [IN_TDATA_W-IN_USED_W-1:0] pad;
    logic [VAL_W-1:0]                value;
    logic [POS_W-1:0]                position;
    logic [MODE_W-1:0]               mode;
  } in_word_t;

  // Result item as packed on out_tdata, lowest field last.
  typedef struct packed {
    logic [OUT_TDATA_W-OUT_USED_W-1:0] pad;
    logic [CHG_W-1:0]                  change_number;
    logic [CNT_W-1:0]                  entry_count;
    logic [RDV_W-1:0]                  read_value;
    status_t                           status;
  } out_word_t;

endpackage

// File: rtl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store: fixed-capacity ordered list with indexed access
// Push, pop, insert, remove, get, set and clear on a list held in one
// simple dual-port memory, with a change counter and a write lock.
// ----------------------------------------------------------------------------
//
//   channel | ports                        | item
//   --------+------------------------------+-----------------------------------
//   in      | in_tvalid/in_tready/in_tdata | mode, position, value
//   out     | out_tvalid/out_tready/out_tdata | status, read_value, entry_count,
//           |                              | change_number
//   cfg     | cfg_we/cfg_wdata             | write_lock
//
// Push, set, clear and every failing item go from idle straight to the done
// state; pop and get pass through a read state first. Insert below the end
// (insert at the end needs no shift) and remove walk the entries above the
// position, and the shift moves one entry a cycle through the memory's single
// write port. One item is in flight at a time; the next is accepted while the
// previous result waits in the output register.
// Reset clears count, lock and output valid and sets the change counter to
// one; the memory needs no clearing pass.
//
module indexed_list_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata: mode[2:0], position[12:3], value[44:13], zeros[47:45]
  input  logic [ils_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: status[1:0], read_value[33:2], entry_count[44:34],
  //            change_number[108:45], zeros[111:109]
  output logic [ils_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata
);

  import ils_pkg::*;

  in_word_t         in_word;
  mem_req_t         mem_req;
  logic [WIDTH-1:0] mem_rdata;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid_r;
  out_word_t        out_word_r;

  assign in_word = in_word_t'(in_tdata);

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_word.mode),
    .in_pos    (in_word.position),
    .in_val    (in_word.value),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  ils_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Output register: free when empty or being taken this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word_r.pad           <= '0;
      out_word_r.change_number <= res.change_number;
      out_word_r.entry_count   <= res.entry_count;
      out_word_r.read_value    <= res.read_value;
      out_word_r.status        <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_word_r);

endmodule

// File: rtl/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl: operation sequencer of the indexed list store
// Decodes one item, checks lock, range and fullness, drives the element
// memory (including the shift loops of insert and remove) and keeps the
// count, the change counter and the lock register.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ils_pkg::MODE_W-1:0] in_mode,
  input  logic [ils_pkg::POS_W-1:0]  in_pos,
  input  logic [ils_pkg::VAL_W-1:0]  in_val,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  output ils_pkg::mem_req_t       mem_req,
  input  logic [ils_pkg::WIDTH-1:0] mem_rdata,
  output logic                    res_valid,
  output ils_pkg::result_t        res,
  input  logic                    res_ready
);

  import ils_pkg::*;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CHG_W-1:0] mcnt_r, mcnt_nxt;
  logic             lock_r;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [WIDTH-1:0] val_r, val_nxt;
  logic [WIDTH-1:0] rdval_r, rdval_nxt;
  status_t          status_r, status_nxt;

  logic [CW-1:0]    pos_c;
  logic [WIDTH-1:0] val_c;
  mode_t            mode_c;
  logic [CW-1:0]    cnt_inc, cnt_dec;
  logic [CW-1:0]    idx_inc, idx_inc2, idx_dec, idx_dec2;
  logic [CHG_W-1:0] mcnt_inc;
  logic             full_c;

  assign pos_c    = CW'(in_pos);
  assign val_c    = in_val[WIDTH-1:0];
  assign mode_c   = mode_t'(in_mode);
  assign cnt_inc  = count_r + CW'(1);
  assign cnt_dec  = count_r - CW'(1);
  assign idx_inc  = idx_r + CW'(1);
  assign idx_inc2 = idx_r + CW'(2);
  assign idx_dec  = idx_r - CW'(1);
  assign idx_dec2 = idx_r - CW'(2);
  assign mcnt_inc = mcnt_r + CHG_W'(1);
  assign full_c   = (count_r >= CW'(DEPTH));

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      mcnt_r  <= CHG_W'(1);
      lock_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      mcnt_r  <= mcnt_nxt;
      if (cfg_we) begin
        lock_r <= cfg_wdata;
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    rdval_r  <= rdval_nxt;
    status_r <= status_nxt;
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    mcnt_nxt   = mcnt_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    rdval_nxt  = rdval_r;
    status_nxt = status_r;
    mem_req    = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pos_nxt    = pos_c;
          val_nxt    = val_c;
          idx_nxt    = pos_c;
          rdval_nxt  = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          unique case (mode_c)
            MODE_PUSH: begin
              if (lock_r) begin
                status_nxt = ST_LOCKED;
              end else if (full_c) begin
                status_nxt = ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count_r[AW-1:0];
                mem_req.wdata = val_c;
                count_nxt     = cnt_inc;
                mcnt_nxt      = mcnt_inc;
              end
            end
            MODE_POP: begin
              if (lock_r) begin
                status_nxt = ST_LOCKED;
              end else if (count_r == '0) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cnt_dec[AW-1:0];
                count_nxt     = cnt_dec;
                mcnt_nxt      = mcnt_inc;
                state_nxt     = S_READ;
              end
            end
            MODE_INSERT: begin
              if (lock_r) begin
                status_nxt = ST_LOCKED;
              end else if (pos_c > count_r) begin
                status_nxt = ST_RANGE;
              end else if (full_c) begin
                status_nxt = ST_FULL;
              end else if (pos_c == count_r) begin
                // Insert at the end needs no shift.
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_c[AW-1:0];
                mem_req.wdata = val_c;
                count_nxt     = cnt_inc;
                mcnt_nxt      = mcnt_inc;
              end else begin
                // Move entries up from the top, one a cycle.
                mem_req.re    = 1'b1;
                mem_req.raddr = cnt_dec[AW-1:0];
                idx_nxt       = count_r;
                state_nxt     = S_INS_SHIFT;
              end
            end
            MODE_REMOVE: begin
              if (lock_r) begin
                status_nxt = ST_LOCKED;
              end else if (pos_c >= count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = pos_c[AW-1:0];
                state_nxt     = S_REM_HEAD;
              end
            end
            MODE_GET: begin
              if (pos_c >= count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = pos_c[AW-1:0];
                state_nxt     = S_READ;
              end
            end
            MODE_SET: begin
              if (lock_r) begin
                status_nxt = ST_LOCKED;
              end else if (pos_c >= count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_c[AW-1:0];
                mem_req.wdata = val_c;
                mcnt_nxt      = mcnt_inc;
              end
            end
            MODE_CLEAR: begin
              if (lock_r) begin
                status_nxt = ST_LOCKED;
              end else begin
                count_nxt = '0;
                mcnt_nxt  = mcnt_inc;
              end
            end
            default: begin
              status_nxt = ST_RANGE;
            end
          endcase
        end
      end

      // Read data of a pop or get arrives.
      S_READ: begin
        rdval_nxt = mem_rdata;
        state_nxt = S_DONE;
      end

      // Removed element arrives; start moving the tail down.
      S_REM_HEAD: begin
        rdval_nxt = mem_rdata;
        if (idx_inc < count_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_inc[AW-1:0];
          state_nxt     = S_REM_SHIFT;
        end else begin
          count_nxt = cnt_dec;
          mcnt_nxt  = mcnt_inc;
          state_nxt = S_DONE;
        end
      end

      // Entry above idx arrives and is written at idx.
      S_REM_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r[AW-1:0];
        mem_req.wdata = mem_rdata;
        idx_nxt       = idx_inc;
        if (idx_inc2 < count_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_inc2[AW-1:0];
        end else begin
          count_nxt = cnt_dec;
          mcnt_nxt  = mcnt_inc;
          state_nxt = S_DONE;
        end
      end

      // Entry below idx arrives and is written at idx.
      S_INS_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r[AW-1:0];
        mem_req.wdata = mem_rdata;
        idx_nxt       = idx_dec;
        if (idx_dec > pos_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_dec2[AW-1:0];
        end else begin
          state_nxt = S_INS_PUT;
        end
      end

      // The gap is open; place the new element.
      S_INS_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r[AW-1:0];
        mem_req.wdata = val_r;
        count_nxt     = cnt_inc;
        mcnt_nxt      = mcnt_inc;
        state_nxt     = S_DONE;
      end

      // Hand the result to the output stage.
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status        = status_r;
  assign res.read_value    = RDV_W'(rdval_r);
  assign res.entry_count   = CNT_W'(count_r);
  assign res.change_number = mcnt_r;

endmodule

// File: rtl/ils_checker.sv
// ----------------------------------------------------------------------------
// ils_checker: port-level checks of the indexed list store
// Watches the channels of the top level; attached by a bind statement.
// ----------------------------------------------------------------------------
module ils_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ils_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import ils_pkg::*;

  out_word_t ow;

  assign ow = out_word_t'(out_tdata);

  // A stalled result item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // Only one item is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in flight");

  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ow.entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  // A failed item returns no element.
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ow.status != ST_OK |-> ow.read_value == '0)
    else $error("read value on a failed item");

  // Full is reported only when the list is at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ow.status == ST_FULL |-> ow.entry_count == CNT_W'(DEPTH))
    else $error("full status below capacity");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
